>>> rtl/pms_pkg.sv
package pms_pkg;

  // configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_GRAV_X   = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRAV_Y   = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRIC_X   = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_FRIC_Y   = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_BOUNCE   = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_GROUND   = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_FADE_OUT = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_MODE     = 4'd7;

  // item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SPAWN = 2'd1;
  localparam logic [1:0] OP_KILL  = 2'd2;

  // mode bits
  localparam int ModeBounce = 0;
  localparam int ModeKill   = 1;

  localparam logic [16:0] OneQ16 = 17'd65536;
  localparam logic [31:0] OneQ30 = 32'h4000_0000;
  localparam logic signed [25:0] CntMin = {1'b1, 25'd0};

  typedef struct packed {
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic [16:0]        fric_x;
    logic [16:0]        fric_y;
    logic [16:0]        bounce;
    logic signed [31:0] ground;
    logic [16:0]        fade_out;
    logic [1:0]         mode;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_GX, S_GY, S_GW, S_PI, S_SQ, S_NL, S_E, S_EX, S_PD,
    S_FX, S_FY, S_MX, S_MY, S_BN, S_BW, S_FD, S_LF, S_OUT
  } state_e;

  typedef logic [15:0][31:0] fac_arr_t;

  // clamp a Q1.16 factor to one
  function automatic logic [16:0] cap_unit(input logic [16:0] v);
    return (v > OneQ16) ? OneQ16 : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [35:0] v);
    if (v > 36'sd131071) return 18'sh1ffff;
    else if (v < -36'sd131072) return 18'sh20000;
    else return v[17:0];
  endfunction

  // frame counter minus elapsed frames, floored at the counter minimum
  function automatic logic signed [25:0] cnt_sub(input logic signed [25:0] c,
                                                 input logic [15:0] d);
    logic signed [26:0] s;
    s = 27'(c) - $signed({11'd0, d});
    if (s < 27'(CntMin)) return CntMin;
    else return s[25:0];
  endfunction

  // elaboration-time integer square root
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] rem;
    res = '0;
    b   = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // factors 2^(-2^-k) in Q30, k = 1..16, each the root of the one before
  function automatic fac_arr_t build_facs();
    fac_arr_t    t;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      c = isqrt64(c << 30);
      t[k] = c[31:0];
    end
    return t;
  endfunction

  localparam fac_arr_t PowFac = build_facs();

endpackage

>>> rtl/pms_in_if.sv
interface pms_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        frame_step;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_vx;
  logic signed [31:0] start_vy;
  logic [16:0]        start_alpha;
  logic [23:0]        life_frames;
  logic [23:0]        delay_frames;
  logic signed [17:0] fade_in_rate;
  logic [16:0]        alpha_ceiling;

  modport source (
    output valid, op, frame_step, start_x, start_y, start_vx, start_vy,
           start_alpha, life_frames, delay_frames, fade_in_rate, alpha_ceiling,
    input  ready
  );
  modport sink (
    input  valid, op, frame_step, start_x, start_y, start_vx, start_vy,
           start_alpha, life_frames, delay_frames, fade_in_rate, alpha_ceiling,
    output ready
  );
endinterface

>>> rtl/pms_out_if.sv
interface pms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [17:0] opacity;
  logic               visible;
  logic               alive;
  logic               started_now;
  logic               bounced_now;
  logic               died_now;

  modport source (
    output valid, pos_x, pos_y, opacity, visible, alive, started_now,
           bounced_now, died_now,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, opacity, visible, alive, started_now,
           bounced_now, died_now,
    output ready
  );
endinterface

>>> rtl/pms_cfg.sv
module pms_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [pms_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [pms_pkg::CfgDataW-1:0] data_i,
  output pms_pkg::cfg_t                cfg_o
);
  import pms_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // decode one register write, factors clamped to one
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_GRAV_X:   cfg_d.grav_x   = data_i;
        CFG_GRAV_Y:   cfg_d.grav_y   = data_i;
        CFG_FRIC_X:   cfg_d.fric_x   = cap_unit(data_i[16:0]);
        CFG_FRIC_Y:   cfg_d.fric_y   = cap_unit(data_i[16:0]);
        CFG_BOUNCE:   cfg_d.bounce   = cap_unit(data_i[16:0]);
        CFG_GROUND:   cfg_d.ground   = data_i;
        CFG_FADE_OUT: cfg_d.fade_out = cap_unit(data_i[16:0]);
        CFG_MODE:     cfg_d.mode     = data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grav_x   <= '0;
      cfg_q.grav_y   <= '0;
      cfg_q.fric_x   <= OneQ16;
      cfg_q.fric_y   <= OneQ16;
      cfg_q.bounce   <= OneQ16;
      cfg_q.ground   <= '0;
      cfg_q.fade_out <= '0;
      cfg_q.mode     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/particle_motion_step_unit.sv
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   op, frame_step, spawn state (positions, velocities, alpha, ...)
// out_o    out  valid/ready   pos_x, pos_y, opacity, visible, alive, event flags
// cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i (no read-back)
//
// Spawn, kill, unused op and a non-moving tick go from accept straight to the result.
// A moving tick also runs the gravity, friction, motion, bounce and fade states and may
// compute both friction powers; each power runs on the single shared 32x32 multiplier (16 squarings,
// one scale, 16 exp2 factor products, all chained through one product register).
// in_i.ready is high only while the sequencer is idle; one result register sits on
// the output, so the next item is taken while a result waits.
// Reset is asynchronous and leaves no particle (alive low).
module particle_motion_step_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pms_in_if.sink                       in_i,
  pms_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [pms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pms_pkg::CfgDataW-1:0] cfg_data_i
);
  import pms_pkg::*;

  cfg_t cfg;

  pms_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  state_e state_q, state_d;

  // particle state
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [31:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic signed [17:0] alpha_q, alpha_d, fin_q, fin_d;
  logic [16:0]        ceil_q, ceil_d;
  logic signed [25:0] life_q, life_d, delay_q, delay_d;
  logic               dead_q, dead_d, started_q, started_d;
  logic               st_now_q, st_now_d, bn_now_q, bn_now_d, die_now_q, die_now_d;

  // sequencer scratch
  logic [15:0]        dfr_q, dfr_d;
  logic               ax_q, ax_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [3:0]         p_q, p_d;
  logic [31:0]        xr_q, xr_d;
  logic [15:0]        frac_q, frac_d, ef_q, ef_d;
  logic [4:0]         ei_q, ei_d;
  logic [16:0]        pw_q, pw_d, px_q, px_d, py_q, py_d;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;

  // output register
  logic               out_vld_q, out_vld_d, out_load;
  logic signed [31:0] o_pos_x_q, o_pos_y_q;
  logic signed [17:0] o_alpha_q;
  logic [4:0]         o_flags_q;

  // shared decode
  logic               in_acc;
  logic signed [25:0] delay_new;
  logic               moving;
  logic [16:0]        f_sel;
  logic               pw_one, pw_zero;
  logic [3:0]         msb;
  logic [33:0]        sq_t;
  logic [31:0]        xn;
  logic [20:0]        nl;
  logic [27:0]        e_val;
  logic [31:0]        rn, rsh;
  logic [31:0]        fac;
  logic               bounce_hit;
  logic signed [17:0] a_in, a_out;
  logic               out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign delay_new  = cnt_sub(delay_q, in_i.frame_step);
  assign moving     = (delay_new <= 26'sd0) && !dead_q;
  assign out_free   = !out_vld_q || out_o.ready;

  // power operands and special cases
  assign f_sel   = ax_q ? cfg.fric_y : cfg.fric_x;
  assign pw_one  = (f_sel >= OneQ16) || (dfr_q == 16'd0);
  assign pw_zero = (f_sel == 17'd0);

  always_comb begin
    msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (f_sel[i]) msb = 4'(i);
    end
  end

  // squaring step: Q1.30 square, renormalized, next log2 fraction bit
  assign sq_t  = prod_q[63:30];
  assign xn    = sq_t[31] ? sq_t[32:1] : sq_t[31:0];
  assign nl    = {5'(5'd16 - {1'b0, p_q}), 16'd0} - {5'd0, frac_q};
  assign e_val = prod_q[35:8];
  // exp2 step
  assign rn    = prod_q[61:30];
  assign rsh   = rn >> (5'd14 + ei_q);
  assign fac   = ef_q[4'd15 - cnt_q[3:0]] ? PowFac[cnt_q[3:0]] : OneQ30;

  assign bounce_hit = cfg.mode[ModeBounce] && (vel_y_q > 32'sd0) &&
                      (pos_y_q >= cfg.ground);
  assign a_in  = sat18(36'(alpha_q) + 36'(prod_q >>> 8));
  assign a_out = sat18(36'(alpha_q) - $signed({19'd0, cfg.fade_out}));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        state_d = (in_i.op == OP_TICK && moving) ? S_GX : S_OUT;
      end
      S_GX: state_d = S_GY;
      S_GY: state_d = S_GW;
      S_GW: state_d = S_PI;
      S_PI: state_d = (pw_one || pw_zero) ? S_PD : S_SQ;
      S_SQ: if (cnt_q == 5'd16) state_d = S_NL;
      S_NL: state_d = S_E;
      S_E:  state_d = (e_val[27:16] > 12'd16) ? S_PD : S_EX;
      S_EX: if (cnt_q == 5'd16) state_d = S_PD;
      S_PD: state_d = ax_q ? S_FX : S_PI;
      S_FX: state_d = S_FY;
      S_FY: state_d = S_MX;
      S_MX: state_d = S_MY;
      S_MY: state_d = S_BN;
      S_BN: state_d = S_BW;
      S_BW: state_d = S_FD;
      S_FD: state_d = S_LF;
      S_LF: state_d = S_OUT;
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and multiplier operands
  always_comb begin
    pos_x_d = pos_x_q;  pos_y_d = pos_y_q;
    vel_x_d = vel_x_q;  vel_y_d = vel_y_q;
    alpha_d = alpha_q;  fin_d   = fin_q;   ceil_d = ceil_q;
    life_d  = life_q;   delay_d = delay_q;
    dead_d  = dead_q;   started_d = started_q;
    st_now_d = st_now_q; bn_now_d = bn_now_q; die_now_d = die_now_q;
    dfr_d = dfr_q; ax_d = ax_q; cnt_d = cnt_q; p_d = p_q; xr_d = xr_q;
    frac_d = frac_q; ef_d = ef_q; ei_d = ei_q; pw_d = pw_q;
    px_d = px_q; py_d = py_q;
    mul_a = '0;
    mul_b = '0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: if (in_acc) begin
        dfr_d     = in_i.frame_step;
        st_now_d  = 1'b0;
        bn_now_d  = 1'b0;
        die_now_d = 1'b0;
        if (in_i.op == OP_SPAWN) begin
          pos_x_d   = in_i.start_x;
          pos_y_d   = in_i.start_y;
          vel_x_d   = in_i.start_vx;
          vel_y_d   = in_i.start_vy;
          alpha_d   = {1'b0, cap_unit(in_i.start_alpha)};
          life_d    = {2'b0, in_i.life_frames};
          delay_d   = {2'b0, in_i.delay_frames};
          ceil_d    = cap_unit(in_i.alpha_ceiling);
          if (in_i.fade_in_rate > 18'sd65536) fin_d = 18'sd65536;
          else if (in_i.fade_in_rate < -18'sd65536) fin_d = -18'sd65536;
          else fin_d = in_i.fade_in_rate;
          dead_d    = 1'b0;
          started_d = 1'b0;
        end else if (in_i.op == OP_KILL) begin
          die_now_d = !dead_q;
          alpha_d   = '0;
          life_d    = '0;
          dead_d    = 1'b1;
        end else if (in_i.op == OP_TICK) begin
          delay_d = delay_new;
          if (moving && !started_q) begin
            started_d = 1'b1;
            st_now_d  = 1'b1;
          end
        end
      end
      // gravity
      S_GX: begin
        mul_a = cfg.grav_x;
        mul_b = $signed({16'd0, dfr_q});
      end
      S_GY: begin
        vel_x_d = sat32(64'(vel_x_q) + (prod_q >>> 8));
        mul_a   = cfg.grav_y;
        mul_b   = $signed({16'd0, dfr_q});
      end
      S_GW: begin
        vel_y_d = sat32(64'(vel_y_q) + (prod_q >>> 8));
        ax_d    = 1'b0;
      end
      // friction power: log2 by squaring
      S_PI: begin
        if (pw_one) pw_d = OneQ16;
        else if (pw_zero) pw_d = '0;
        else begin
          p_d    = msb;
          xr_d   = {15'd0, f_sel} << (5'd30 - {1'b0, msb});
          frac_d = '0;
          cnt_d  = '0;
        end
      end
      S_SQ: begin
        if (cnt_q == 5'd0) begin
          mul_a = xr_q;
          mul_b = xr_q;
          cnt_d = cnt_q + 5'd1;
        end else begin
          xr_d   = xn;
          frac_d = {frac_q[14:0], sq_t[31]};
          if (cnt_q != 5'd16) begin
            mul_a = xn;
            mul_b = xn;
            cnt_d = cnt_q + 5'd1;
          end
        end
      end
      S_NL: begin
        mul_a = $signed({11'd0, nl});
        mul_b = $signed({16'd0, dfr_q});
      end
      S_E: begin
        if (e_val[27:16] > 12'd16) pw_d = '0;
        else begin
          ei_d  = e_val[20:16];
          ef_d  = e_val[15:0];
          xr_d  = OneQ30;
          cnt_d = '0;
        end
      end
      // exp2 of the fraction, then the integer shift
      S_EX: begin
        if (cnt_q == 5'd0) begin
          mul_a = xr_q;
          mul_b = fac;
          cnt_d = cnt_q + 5'd1;
        end else begin
          xr_d = rn;
          if (cnt_q == 5'd16) begin
            pw_d = (rsh > 32'(OneQ16)) ? OneQ16 : rsh[16:0];
          end else begin
            mul_a = rn;
            mul_b = fac;
            cnt_d = cnt_q + 5'd1;
          end
        end
      end
      S_PD: begin
        if (ax_q) py_d = pw_q;
        else px_d = pw_q;
        ax_d = 1'b1;
      end
      // friction scale and motion
      S_FX: begin
        mul_a = vel_x_q;
        mul_b = $signed({15'd0, px_q});
      end
      S_FY: begin
        vel_x_d = sat32(prod_q >>> 16);
        mul_a   = vel_y_q;
        mul_b   = $signed({15'd0, py_q});
      end
      S_MX: begin
        vel_y_d = sat32(prod_q >>> 16);
        mul_a   = vel_x_q;
        mul_b   = $signed({16'd0, dfr_q});
      end
      S_MY: begin
        pos_x_d = sat32(64'(pos_x_q) + (prod_q >>> 8));
        mul_a   = vel_y_q;
        mul_b   = $signed({16'd0, dfr_q});
      end
      S_BN: begin
        pos_y_d = sat32(64'(pos_y_q) + (prod_q >>> 8));
        mul_a   = vel_y_q;
        mul_b   = $signed({15'd0, cfg.bounce});
      end
      // ground bounce
      S_BW: begin
        if (bounce_hit) begin
          vel_y_d  = 32'(-(prod_q >>> 16));
          pos_y_d  = sat32(64'(cfg.ground) - 64'sd65536);
          bn_now_d = 1'b1;
        end
        mul_a = 32'(fin_q);
        mul_b = $signed({16'd0, dfr_q});
      end
      // fade-in and life count
      S_FD: begin
        if ((life_q > 26'sd0) && (fin_q != 18'sd0)) begin
          if (a_in > $signed({1'b0, ceil_q})) begin
            fin_d   = '0;
            alpha_d = {1'b0, ceil_q};
          end else begin
            alpha_d = a_in;
          end
        end
        life_d = cnt_sub(life_q, dfr_q);
      end
      // fade-out and death
      S_LF: begin
        if (life_q <= 26'sd0) begin
          alpha_d = a_out;
          if ((a_out <= 18'sd0) || cfg.mode[ModeKill]) begin
            die_now_d = 1'b1;
            alpha_d   = '0;
            life_d    = '0;
            dead_d    = 1'b1;
          end
        end
      end
      S_OUT: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  // control and particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      vel_x_q   <= '0;
      vel_y_q   <= '0;
      alpha_q   <= '0;
      fin_q     <= '0;
      ceil_q    <= '0;
      life_q    <= '0;
      delay_q   <= '0;
      dead_q    <= 1'b1;
      started_q <= 1'b0;
      st_now_q  <= 1'b0;
      bn_now_q  <= 1'b0;
      die_now_q <= 1'b0;
      ax_q      <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      vel_x_q   <= vel_x_d;
      vel_y_q   <= vel_y_d;
      alpha_q   <= alpha_d;
      fin_q     <= fin_d;
      ceil_q    <= ceil_d;
      life_q    <= life_d;
      delay_q   <= delay_d;
      dead_q    <= dead_d;
      started_q <= started_d;
      st_now_q  <= st_now_d;
      bn_now_q  <= bn_now_d;
      die_now_q <= die_now_d;
      ax_q      <= ax_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // scratch, shared product and result payload
  always_ff @(posedge clk_i) begin
    dfr_q  <= dfr_d;
    p_q    <= p_d;
    xr_q   <= xr_d;
    frac_q <= frac_d;
    ef_q   <= ef_d;
    ei_q   <= ei_d;
    pw_q   <= pw_d;
    px_q   <= px_d;
    py_q   <= py_d;
    prod_q <= mul_a * mul_b;
    if (out_load) begin
      o_pos_x_q <= pos_x_q;
      o_pos_y_q <= pos_y_q;
      o_alpha_q <= alpha_q;
      o_flags_q <= {delay_q <= 26'sd0, !dead_q, st_now_q, bn_now_q, die_now_q};
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.pos_x       = o_pos_x_q;
  assign out_o.pos_y       = o_pos_y_q;
  assign out_o.opacity     = o_alpha_q;
  assign out_o.visible     = o_flags_q[4];
  assign out_o.alive       = o_flags_q[3];
  assign out_o.started_now = o_flags_q[2];
  assign out_o.bounced_now = o_flags_q[1];
  assign out_o.died_now    = o_flags_q[0];

`ifndef SYNTHESIS
  // no particle means cleared alpha and life
  a_dead_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead_q |-> (alpha_q == 18'sd0) && (life_q == 26'sd0))
    else $error("dead particle holds alpha or life");

  // step counter stays within one power pass
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'd16)
    else $error("step counter out of range");

  // powers never exceed one when they scale the velocity
  a_pow_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FX) |-> (px_q <= OneQ16) && (py_q <= OneQ16))
    else $error("friction power above one");

  // squaring operand stays normalized below two
  a_sq_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ) |-> !xr_q[31])
    else $error("squaring operand overflow");

  // a result is only loaded when the output register is free
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready && state_q == S_OUT) |=> (state_q == S_OUT))
    else $error("result overwritten while pending");
`endif

endmodule

>>> test/tb_particle_motion_step_unit.sv
module tb_particle_motion_step_unit;
  import pms_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 120;

  // opcode with no function and a register index past the last register
  localparam logic [1:0]         OpUnused     = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 4'd15;

  typedef struct {
    logic [1:0]         op;
    logic [15:0]        frame_step;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_vx;
    logic signed [31:0] start_vy;
    logic [16:0]        start_alpha;
    logic [23:0]        life_frames;
    logic [23:0]        delay_frames;
    logic signed [17:0] fade_in_rate;
    logic [16:0]        alpha_ceiling;
  } particle_cmd_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [17:0] opacity;
    logic               visible;
    logic               alive;
    logic               started_now;
    logic               bounced_now;
    logic               died_now;
  } particle_view_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  pms_in_if  in_bus ();
  pms_out_if out_bus ();

  particle_motion_step_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus.sink),
    .out_o      (out_bus.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predicted views, oldest first
  particle_view_t pending_views[$];
  int err_cnt;
  int idle_cycles;
  int src_idle_pct;
  int snk_idle_pct;

  // mirrored configuration
  longint grav_x, grav_y, ground;
  longint fric_x, fric_y, bounce_gain, fade_out;
  logic [1:0] mode;

  // mirrored particle state
  longint px, py, vx, vy, alpha, fade_in, life, delay;
  longint ceiling;
  bit dead, started;

  always #5 clk_i = ~clk_i;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint clamp32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint unit_cap(longint unsigned v);
    v = v & 64'h1ffff;
    return (v > 65536) ? 65536 : longint'(v);
  endfunction

  // bitwise integer square root, result below 2^32
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  // f^n, f in Q1.16, n in Q8.8, via log2 by squaring and exp2 by root factors
  function automatic longint unsigned friction_pow(longint unsigned f, longint unsigned n);
    int unsigned msb;
    longint unsigned x, frac, nl, e, ei, ef, r, c;
    if (f >= 65536 || n == 0) return 65536;
    if (f == 0) return 0;
    msb = 0;
    for (int i = 0; i < 16; i++) if (f[i]) msb = i;
    x = f << (30 - msb);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    nl = (longint'(16 - msb) << 16) - frac;
    e  = (nl * n) >> 8;
    ei = e >> 16;
    ef = e & 64'hffff;
    if (ei > 16) return 0;
    r = 64'd1 << 30;
    c = 64'd1 << 29;
    for (int k = 1; k <= 16; k++) begin
      c = int_root(c << 30);
      if (ef[16-k]) r = (r * c) >> 30;
    end
    r = r >> (14 + ei);
    return (r > 65536) ? 65536 : r;
  endfunction

  task automatic reset_model();
    grav_x = 0; grav_y = 0; ground = 0;
    fric_x = 65536; fric_y = 65536; bounce_gain = 65536; fade_out = 0; mode = '0;
    px = 0; py = 0; vx = 0; vy = 0; alpha = 0; fade_in = 0; life = 0; delay = 0;
    ceiling = 0; dead = 1; started = 0;
  endtask

  function automatic void apply_config(logic [CfgIdxW-1:0] idx, logic [31:0] d);
    case (idx)
      CFG_GRAV_X:   grav_x = longint'($signed(d));
      CFG_GRAV_Y:   grav_y = longint'($signed(d));
      CFG_FRIC_X:   fric_x = unit_cap(64'(d));
      CFG_FRIC_Y:   fric_y = unit_cap(64'(d));
      CFG_BOUNCE:   bounce_gain = unit_cap(64'(d));
      CFG_GROUND:   ground = longint'($signed(d));
      CFG_FADE_OUT: fade_out = unit_cap(64'(d));
      CFG_MODE:     mode = d[1:0];
      default: ;
    endcase
  endfunction

  // advance the mirrored particle by one command and return the view it yields
  function automatic particle_view_t step_particle(particle_cmd_t c);
    particle_view_t v;
    longint dfr;
    longint pwx, pwy;
    bit st, bn, dd;
    st = 0; bn = 0; dd = 0;
    dfr = longint'(c.frame_step);
    case (c.op)
      OP_SPAWN: begin
        px = longint'(c.start_x); py = longint'(c.start_y);
        vx = longint'(c.start_vx); vy = longint'(c.start_vy);
        alpha = unit_cap(64'(c.start_alpha));
        life = longint'(c.life_frames);
        delay = longint'(c.delay_frames);
        fade_in = clamp(longint'(c.fade_in_rate), -65536, 65536);
        ceiling = unit_cap(64'(c.alpha_ceiling));
        dead = 0; started = 0;
      end
      OP_KILL: begin
        dd = !dead;
        alpha = 0; life = 0; dead = 1;
      end
      OP_TICK: begin
        delay = clamp(delay - dfr, -33554432, 64'sh7fffffffffffffff);
        if (delay <= 0 && !dead) begin
          if (!started) begin
            started = 1;
            st = 1;
          end
          vx = clamp32(vx + ((grav_x * dfr) >>> 8));
          vy = clamp32(vy + ((grav_y * dfr) >>> 8));
          pwx = longint'(friction_pow(fric_x, dfr));
          pwy = longint'(friction_pow(fric_y, dfr));
          vx = clamp32((vx * pwx) >>> 16);
          vy = clamp32((vy * pwy) >>> 16);
          px = clamp32(px + ((vx * dfr) >>> 8));
          py = clamp32(py + ((vy * dfr) >>> 8));
          if (mode[ModeBounce] && vy > 0 && py >= ground) begin
            vy = -((vy * bounce_gain) >>> 16);
            py = clamp32(ground - 65536);
            bn = 1;
          end
          if (life > 0 && fade_in != 0) begin
            alpha = clamp(alpha + ((fade_in * dfr) >>> 8), -131072, 131071);
            if (alpha > ceiling) begin
              fade_in = 0;
              alpha = ceiling;
            end
          end
          life = clamp(life - dfr, -33554432, 64'sh7fffffffffffffff);
          if (life <= 0) alpha = clamp(alpha - fade_out, -131072, 131071);
          if (life <= 0 && (alpha <= 0 || mode[ModeKill])) begin
            dd = 1;
            alpha = 0; life = 0; dead = 1;
          end
        end
      end
      default: ;
    endcase
    v.pos_x = px[31:0];
    v.pos_y = py[31:0];
    v.opacity = alpha[17:0];
    v.visible = (delay <= 0);
    v.alive = !dead;
    v.started_now = st;
    v.bounced_now = bn;
    v.died_now = dd;
    return v;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // result checking and watchdog
  always @(posedge clk_i) begin
    particle_view_t want;
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_views.size() == 0) begin
          $display("%0t: unexpected result transaction pos_x=%0d", $time, out_bus.pos_x);
          err_cnt++;
        end else begin
          want = pending_views.pop_front();
          check_field("pos_x", want.pos_x, out_bus.pos_x);
          check_field("pos_y", want.pos_y, out_bus.pos_y);
          check_field("opacity", want.opacity, out_bus.opacity);
          check_field("visible", want.visible, out_bus.visible);
          check_field("alive", want.alive, out_bus.alive);
          check_field("started_now", want.started_now, out_bus.started_now);
          check_field("bounced_now", want.bounced_now, out_bus.bounced_now);
          check_field("died_now", want.died_now, out_bus.died_now);
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_views.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk_i) out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);

  task automatic send(particle_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.op            <= c.op;
    in_bus.frame_step    <= c.frame_step;
    in_bus.start_x       <= c.start_x;
    in_bus.start_y       <= c.start_y;
    in_bus.start_vx      <= c.start_vx;
    in_bus.start_vy      <= c.start_vy;
    in_bus.start_alpha   <= c.start_alpha;
    in_bus.life_frames   <= c.life_frames;
    in_bus.delay_frames  <= c.delay_frames;
    in_bus.fade_in_rate  <= c.fade_in_rate;
    in_bus.alpha_ceiling <= c.alpha_ceiling;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_views = {pending_views, step_particle(c)};
  endtask

  // drain all results, then let the sequencer settle
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] d);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    apply_config(idx, d);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic particle_cmd_t noise_cmd(logic [1:0] op, logic [15:0] dfr);
    particle_cmd_t c;
    c.op = op;
    c.frame_step = dfr;
    c.start_x = $urandom; c.start_y = $urandom;
    c.start_vx = $urandom; c.start_vy = $urandom;
    c.start_alpha = 17'($urandom); c.life_frames = 24'($urandom);
    c.delay_frames = 24'($urandom);
    c.fade_in_rate = 18'($urandom); c.alpha_ceiling = 17'($urandom);
    return c;
  endfunction

  function automatic particle_cmd_t spawn_cmd();
    particle_cmd_t c;
    c = noise_cmd(OP_SPAWN, 16'($urandom));
    if ($urandom_range(3) != 0) begin
      c.start_x  = $signed($urandom_range(0, 2 << 20)) - (1 << 20);
      c.start_y  = $signed($urandom_range(0, 2 << 20)) - (1 << 20);
      c.start_vx = $signed($urandom_range(0, 2 << 18)) - (1 << 18);
      c.start_vy = $signed($urandom_range(0, 2 << 18)) - (1 << 18);
    end
    if ($urandom_range(3) != 0) c.start_alpha = 17'($urandom_range(0, 65536));
    if ($urandom_range(4) != 0) c.life_frames = 24'($urandom_range(0, 3000));
    case ($urandom_range(3))
      0: c.delay_frames = 24'd0;
      1, 2: c.delay_frames = 24'($urandom_range(0, 1000));
      default: ;
    endcase
    if ($urandom_range(3) != 0) begin
      c.fade_in_rate = 18'($signed($urandom_range(0, 2048)) - 1024);
    end
    if ($urandom_range(3) != 0) c.alpha_ceiling = 17'($urandom_range(0, 65536));
    return c;
  endfunction

  function automatic logic [15:0] rand_dfr();
    return ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
  endfunction

  function automatic logic [16:0] rand_factor();
    case ($urandom_range(3))
      0: return OneQ16;
      1: return 17'($urandom);
      default: return 17'($urandom_range(40000, 65536));
    endcase
  endfunction

  task automatic random_config();
    cfg_write(CFG_GRAV_X, ($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 8192) - 4096);
    cfg_write(CFG_GRAV_Y, ($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 8192) - 2048);
    cfg_write(CFG_FRIC_X, {15'($urandom_range(0, 32767)), rand_factor()});
    cfg_write(CFG_FRIC_Y, {15'd0, rand_factor()});
    cfg_write(CFG_BOUNCE, {15'd0, rand_factor()});
    cfg_write(CFG_GROUND, $urandom_range(0, 2 << 20) - (1 << 20));
    cfg_write(CFG_FADE_OUT, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4096));
    cfg_write(CFG_MODE, $urandom);
  endtask

  // ticks, kill and an unused opcode with no particle loaded
  task automatic test_no_particle();
    send(noise_cmd(OP_TICK, 16'd256));
    send(noise_cmd(OP_KILL, 16'd0));
    send(noise_cmd(OpUnused, 16'hffff));
    send(noise_cmd(OP_TICK, 16'd0));
  endtask

  // register extremes, out-of-range index, saturating spawn values
  task automatic test_extremes();
    particle_cmd_t c;
    wait_idle();
    cfg_write(CFG_GRAV_X, 32'h7fff_ffff);
    cfg_write(CFG_GRAV_Y, 32'h8000_0000);
    cfg_write(CFG_FRIC_X, 32'hffff_ffff);
    cfg_write(CFG_FRIC_Y, 32'd0);
    cfg_write(CFG_BOUNCE, 32'h0001_ffff);
    cfg_write(CFG_GROUND, 32'h8000_0000);
    cfg_write(CFG_FADE_OUT, 32'h0001_ffff);
    cfg_write(CFG_MODE, 32'd3);
    cfg_write(CfgIdxUnused, 32'hdead_beef);
    c = noise_cmd(OP_SPAWN, 16'd0);
    c.start_x = 32'sh7fff_ffff; c.start_y = 32'sh8000_0000;
    c.start_vx = 32'sh7fff_ffff; c.start_vy = 32'sh8000_0000;
    c.start_alpha = 17'h1ffff; c.life_frames = 24'hffffff; c.delay_frames = 24'd0;
    c.fade_in_rate = 18'sh1ffff; c.alpha_ceiling = 17'h1ffff;
    send(c);
    send(noise_cmd(OP_TICK, 16'hffff));
    send(noise_cmd(OP_TICK, 16'd1));
    c.delay_frames = 24'hffffff; c.fade_in_rate = 18'sh20000; c.life_frames = 24'd0;
    send(c);
    send(noise_cmd(OP_TICK, 16'hffff));
    send(noise_cmd(OP_KILL, 16'd5));
    send(noise_cmd(OP_KILL, 16'd5));
  endtask

  // fall onto ground, fade in to ceiling, fade out and die
  task automatic test_bounce_fade();
    particle_cmd_t c;
    wait_idle();
    cfg_write(CFG_GRAV_X, 32'd0);
    cfg_write(CFG_GRAV_Y, 32'd4096);
    cfg_write(CFG_FRIC_X, 32'd60000);
    cfg_write(CFG_FRIC_Y, 32'd65000);
    cfg_write(CFG_BOUNCE, 32'd45000);
    cfg_write(CFG_GROUND, 32'd0);
    cfg_write(CFG_FADE_OUT, 32'd20000);
    cfg_write(CFG_MODE, 32'd1);
    c = noise_cmd(OP_SPAWN, 16'd0);
    c.start_x = 0; c.start_y = -32'sd131072; c.start_vx = 32'sd65536; c.start_vy = 32'sd65536;
    c.start_alpha = 17'd0; c.life_frames = 24'd1024; c.delay_frames = 24'd200;
    c.fade_in_rate = 18'sd30000; c.alpha_ceiling = 17'd50000;
    send(c);
    send(noise_cmd(OP_TICK, 16'd100));
    for (int i = 0; i < 8; i++) send(noise_cmd(OP_TICK, 16'd256));
    send(noise_cmd(OpUnused, 16'd256));
  endtask

  task automatic test_random(int n_items, int src_pct, int snk_pct);
    int sent;
    int ticks;
    int pick;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(4) == 0) begin
        wait_idle();
        random_config();
      end
      if ($urandom_range(9) != 0) begin
        send(spawn_cmd());
        sent++;
      end
      ticks = $urandom_range(1, 12);
      for (int i = 0; i < ticks; i++) begin
        pick = $urandom_range(39);
        if (pick == 0) send(noise_cmd(OP_KILL, 16'($urandom)));
        else if (pick == 1) send(noise_cmd(OpUnused, 16'($urandom)));
        else send(noise_cmd(OP_TICK, rand_dfr()));
        sent++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_TICK;
    in_bus.frame_step = '0;
    in_bus.start_x = '0; in_bus.start_y = '0;
    in_bus.start_vx = '0; in_bus.start_vy = '0;
    in_bus.start_alpha = '0; in_bus.life_frames = '0; in_bus.delay_frames = '0;
    in_bus.fade_in_rate = '0; in_bus.alpha_ceiling = '0;
    out_bus.ready = 1'b0;
    err_cnt = 0;
    idle_cycles = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    reset_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 36;
    snk_idle_pct = 70;
    test_no_particle();
    test_extremes();
    test_bounce_fade();
    test_random(150, 36, 70);
    test_random(150, 70, 36);
    test_random(150, 0, 0);

    wait_idle();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> particle_motion_step_unit.f
rtl/pms_pkg.sv
rtl/pms_in_if.sv
rtl/pms_out_if.sv
rtl/pms_cfg.sv
rtl/particle_motion_step_unit.sv
test/tb_particle_motion_step_unit.sv
